// ----- rtl/b64d_pkg.sv -----
package b64d_pkg;

    // Sextet codes beyond the 64 data values
    localparam logic [6:0] SX_SPACE = 7'd64;
    localparam logic [6:0] SX_PAD   = 7'd65;
    localparam logic [6:0] SX_BAD   = 7'd66;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [1:0] ST_NO_ROOM  = 2'd2;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = 2;
    localparam int CMDQ_CW    = 3;

    // Work for the back end: up to three bytes, then an optional status
    typedef struct packed {
        logic [1:0]  nbytes;
        logic [23:0] bytes;
        logic        has_status;
        logic [1:0]  status;
        logic [31:0] count;
    } cmd_t;

    function automatic logic [6:0] map_char(input logic [7:0] c);
        logic [6:0] s;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s = 7'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A) begin
            s = 7'(c - 8'h61 + 8'd26);
        end
        else if (c >= 8'h30 && c <= 8'h39) begin
            s = 7'(c - 8'h30 + 8'd52);
        end
        else if (c == 8'h2B) begin
            s = 7'd62;
        end
        else if (c == 8'h2F) begin
            s = 7'd63;
        end
        else if ((c >= 8'd9 && c <= 8'd13) || c == 8'd32) begin
            s = SX_SPACE;
        end
        else if (c == 8'h3D) begin
            s = SX_PAD;
        end
        else begin
            s = SX_BAD;
        end
        return s;
    endfunction

endpackage

// ----- rtl/b64d_front.sv -----
module b64d_front #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [7:0]       char_code,
    input  logic             message_end,
    input  logic             cfg_valid,
    input  logic [31:0]      cfg_data,
    input  logic             q_full,
    output logic             q_wr,
    output b64d_pkg::cmd_t   q_data
);

    localparam logic [1:0] MODE_DECODE  = 2'd0;
    localparam logic [1:0] MODE_PAD     = 2'd1;
    localparam logic [1:0] MODE_DISCARD = 2'd2;

    localparam int LW = ((COUNT_WIDTH > 32) ? COUNT_WIDTH : 32) + 1;
    localparam logic [LW-1:0] CMAX = {{(LW-COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};

    logic [31:0]            cap_reg;
    logic [23:0]            acc_reg, acc_next;
    logic [1:0]             cnt_reg, cnt_next;
    logic [COUNT_WIDTH-1:0] produced_reg, produced_next;
    logic [1:0]             mode_reg, mode_next;

    logic                   accept;
    logic [6:0]             sx;
    logic [23:0]            acc_shift, acc_fin;
    logic [1:0]             cnt_fin;
    logic                   is_data, group, active, bad, room_fail;
    logic [1:0]             tail_n, addend;
    logic [LW-1:0]          sum;
    logic                   over;
    b64d_pkg::cmd_t         cmd;

    assign accept = push && !q_full;

    always_comb
    begin
        sx        = b64d_pkg::map_char(char_code);
        acc_shift = {acc_reg[17:0], sx[5:0]};
        active    = (mode_reg == MODE_DECODE) || (mode_reg == MODE_PAD);
        is_data   = (mode_reg == MODE_DECODE) && !sx[6];
        group     = is_data && (cnt_reg == 2'd3);
        acc_fin   = is_data ? acc_shift : acc_reg;
        cnt_fin   = is_data ? cnt_reg + 2'd1 : cnt_reg;
        case (cnt_fin)
            2'd3:    tail_n = 2'd2;
            2'd2:    tail_n = 2'd1;
            default: tail_n = 2'd0;
        endcase
        addend    = group ? 2'd3 : tail_n;
        sum       = {{(LW-COUNT_WIDTH){1'b0}}, produced_reg} + {{(LW-2){1'b0}}, addend};
        over      = (sum > {{(LW-32){1'b0}}, cap_reg}) || (sum > CMAX);
        bad       = (mode_reg == MODE_DECODE) && (sx == b64d_pkg::SX_BAD);
        room_fail = active && !bad && (group || message_end) && over;

        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        produced_next = produced_reg;
        mode_next     = mode_reg;
        cmd           = '0;

        if (accept) begin
            if (!active) begin
                if (message_end) begin
                    acc_next      = '0;
                    cnt_next      = '0;
                    produced_next = '0;
                    mode_next     = MODE_DECODE;
                end
            end
            else if (bad || room_fail) begin
                cmd.has_status = 1'b1;
                cmd.status     = bad ? b64d_pkg::ST_BAD_CHAR : b64d_pkg::ST_NO_ROOM;
                acc_next       = '0;
                cnt_next       = '0;
                produced_next  = '0;
                mode_next      = message_end ? MODE_DECODE : MODE_DISCARD;
            end
            else begin
                if (mode_reg == MODE_DECODE && sx == b64d_pkg::SX_PAD) begin
                    mode_next = MODE_PAD;
                end
                if (is_data) begin
                    acc_next = group ? 24'd0 : acc_shift;
                    cnt_next = cnt_fin;
                end
                if (group) begin
                    cmd.nbytes    = 2'd3;
                    cmd.bytes     = acc_shift;
                    produced_next = sum[COUNT_WIDTH-1:0];
                end
                if (message_end) begin
                    if (!group) begin
                        cmd.nbytes = tail_n;
                        case (cnt_fin)
                            2'd3:    cmd.bytes = {acc_fin[17:10], acc_fin[9:2], 8'h00};
                            2'd2:    cmd.bytes = {acc_fin[11:4], 16'h0000};
                            default: cmd.bytes = '0;
                        endcase
                    end
                    cmd.has_status = 1'b1;
                    cmd.status     = b64d_pkg::ST_OK;
                    cmd.count      = sum[31:0];
                    acc_next       = '0;
                    cnt_next       = '0;
                    produced_next  = '0;
                    mode_next      = MODE_DECODE;
                end
            end
        end
    end

    assign q_wr   = accept && ((cmd.nbytes != 2'd0) || cmd.has_status);
    assign q_data = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cap_reg      <= 32'hFFFF_FFFF;
            acc_reg      <= '0;
            cnt_reg      <= '0;
            produced_reg <= '0;
            mode_reg     <= MODE_DECODE;
        end
        else begin
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
            acc_reg      <= acc_next;
            cnt_reg      <= cnt_next;
            produced_reg <= produced_next;
            mode_reg     <= mode_next;
        end
    end

    // A finished message leaves the decoder clean for the next one
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && message_end) |=> (mode_reg == MODE_DECODE && cnt_reg == 2'd0
                                     && produced_reg == '0))
        else $error("message end did not clear decoder state");

    // An item with a status is always queued
    a_status_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && message_end && active) |-> (q_wr && cmd.has_status))
        else $error("message end without status");

endmodule

// ----- rtl/b64d_cmd_fifo.sv -----
module b64d_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  b64d_pkg::cmd_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output b64d_pkg::cmd_t rd_data,
    output logic           empty
);

    b64d_pkg::cmd_t                mem [b64d_pkg::CMDQ_DEPTH];
    logic [b64d_pkg::CMDQ_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [b64d_pkg::CMDQ_CW-1:0]  count_reg, count_next;
    logic                          do_wr, do_rd;

    assign full    = (count_reg == b64d_pkg::CMDQ_CW'(b64d_pkg::CMDQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (do_wr) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full))
        else $error("command dropped on full queue");

endmodule

// ----- rtl/b64d_back.sv -----
module b64d_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  b64d_pkg::cmd_t q_data,
    output logic           q_pop,
    output logic           empty,
    input  logic           pop,
    output logic           item_kind,
    output logic [7:0]     decoded_byte,
    output logic [1:0]     status_code,
    output logic [31:0]    byte_count,
    output logic           last_result
);

    b64d_pkg::cmd_t cur_reg;
    logic           cur_valid_reg, cur_valid_next;
    logic [1:0]     idx_reg, idx_next;
    logic           out_valid_reg, out_valid_next;
    logic           kind_reg;
    logic [7:0]     byte_reg;
    logic [1:0]     status_reg;
    logic [31:0]    count_reg;

    logic [2:0]     total;
    logic           is_last, is_byte, out_load, cur_done;
    logic [7:0]     sel_byte;

    always_comb
    begin
        total    = {1'b0, cur_reg.nbytes} + {2'b00, cur_reg.has_status};
        is_last  = ({1'b0, idx_reg} + 3'd1) == total;
        is_byte  = idx_reg < cur_reg.nbytes;
        case (idx_reg)
            2'd0:    sel_byte = cur_reg.bytes[23:16];
            2'd1:    sel_byte = cur_reg.bytes[15:8];
            default: sel_byte = cur_reg.bytes[7:0];
        endcase
        out_load = cur_valid_reg && (!out_valid_reg || pop);
        cur_done = !cur_valid_reg || (out_load && is_last);
        q_pop    = cur_done && !q_empty;

        cur_valid_next = cur_done ? !q_empty : 1'b1;
        if (q_pop) begin
            idx_next = 2'd0;
        end
        else if (out_load) begin
            idx_next = idx_reg + 2'd1;
        end
        else begin
            idx_next = idx_reg;
        end
        out_valid_next = out_load || (out_valid_reg && !pop);
    end

    always_ff @(posedge clk)
    begin
        if (q_pop) begin
            cur_reg <= q_data;
        end
        if (out_load) begin
            kind_reg   <= is_byte ? b64d_pkg::KIND_DATA : b64d_pkg::KIND_STATUS;
            byte_reg   <= is_byte ? sel_byte : 8'h00;
            status_reg <= is_byte ? b64d_pkg::ST_OK : cur_reg.status;
            count_reg  <= is_byte ? 32'd0 : cur_reg.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty        = !out_valid_reg;
    assign item_kind    = kind_reg;
    assign decoded_byte = byte_reg;
    assign status_code  = status_reg;
    assign byte_count   = count_reg;
    assign last_result  = (kind_reg == b64d_pkg::KIND_STATUS);

    // The result index never runs past the work held
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> ({1'b0, idx_reg} < total))
        else $error("result index past end of command");

endmodule

// ----- rtl/base64_stream_decoder_top.sv -----
// Streaming Base64 decoder, one encoded character per item.
// Input queue side: drive char_code and message_end with push; the item is
// taken at a clock edge where push is high and full is low. Whitespace is
// skipped, '=' ends the data of a message, and an invalid character or a
// decoded length beyond the capacity reports an error and drops input up to
// the character marked message_end.
// Result queue side: while empty is low the oldest result is on the result
// ports; pop takes it. Data bytes come first, then one status item per
// message with last_result set and, on success, the decoded length.
// Capacity: write cfg_data with cfg_valid (cfg_ready is always high), only
// while no message is in progress. Reset sets it to all ones.
// Timing: one item per cycle is accepted while the four-entry command queue
// has room; the back end delivers one result per cycle while pop is high, so
// a burst of up to four results for one item stalls input only when the queue
// fills. An item's first result goes through the command queue and the work
// register into the result register. A stalled receiver holds the current
// result and backs up into full. Reset clears decoder state, queues and result valid.
module base64_stream_decoder_top #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  char_code,
    input  logic        message_end,
    output logic        empty,
    input  logic        pop,
    output logic        item_kind,
    output logic [7:0]  decoded_byte,
    output logic [1:0]  status_code,
    output logic [31:0] byte_count,
    output logic        last_result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic           q_full, q_wr, q_empty, q_pop;
    b64d_pkg::cmd_t q_wdata, q_rdata;

    assign full      = q_full;
    assign cfg_ready = 1'b1;

    b64d_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .char_code  (char_code),
        .message_end(message_end),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .q_wr       (q_wr),
        .q_data     (q_wdata)
    );

    b64d_cmd_fifo u_cmdq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_wr),
        .wr_data(q_wdata),
        .full   (q_full),
        .rd_en  (q_pop),
        .rd_data(q_rdata),
        .empty  (q_empty)
    );

    b64d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .item_kind   (item_kind),
        .decoded_byte(decoded_byte),
        .status_code (status_code),
        .byte_count  (byte_count),
        .last_result (last_result)
    );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int COUNT_W      = 32;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_TAIL    = 12;
    localparam int HOLD_CYCLES  = 250;

    // Character classes beyond the 64 data sextets
    localparam int SXT_SKIP = 64;
    localparam int SXT_PAD  = 65;
    localparam int SXT_BAD  = 66;

    localparam logic [7:0] CH_PAD = 8'h3D;

    typedef enum logic [1:0] {DEC_DATA, DEC_PAD, DEC_DROP} dec_mode_t;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } char_item_t;

    typedef struct {
        logic        kind;
        logic [7:0]  data;
        logic [1:0]  status;
        logic [31:0] count;
        logic        last;
    } out_item_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  char_code = '0;
    logic        message_end = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic        item_kind;
    logic [7:0]  decoded_byte;
    logic [1:0]  status_code;
    logic [31:0] byte_count;
    logic        last_result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;

    char_item_t char_stream[$];
    out_item_t  decoder_out_due[$];

    // Decoder mirror
    logic [23:0]       dec_acc = '0;
    int                dec_cnt = 0;
    longint unsigned   dec_made = 0;
    dec_mode_t         dec_mode = DEC_DATA;
    logic [31:0]       cap_model = 32'hFFFF_FFFF;

    bit in_taken = 1'b0;
    bit calm = 1'b0;
    bit rx_hold = 1'b0;
    int src_gap = 0;
    int snk_gap = 0;
    int cycle_cnt = 0;
    int fails = 0;
    int chars_queued = 0;
    int msgs_queued = 0;
    int bytes_seen = 0;
    int full_cycles = 0;
    int status_seen[3] = '{0, 0, 0};

    base64_stream_decoder_top #(.COUNT_WIDTH(COUNT_W)) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .char_code   (char_code),
        .message_end (message_end),
        .empty       (empty),
        .pop         (pop),
        .item_kind   (item_kind),
        .decoded_byte(decoded_byte),
        .status_code (status_code),
        .byte_count  (byte_count),
        .last_result (last_result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int sextet_of(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return c - "A";
        if (c >= "a" && c <= "z")
            return c - "a" + 26;
        if (c >= "0" && c <= "9")
            return c - "0" + 52;
        if (c == "+")
            return 62;
        if (c == "/")
            return 63;
        if ((c >= 8'd9 && c <= 8'd13) || c == 8'd32)
            return SXT_SKIP;
        if (c == CH_PAD)
            return SXT_PAD;
        return SXT_BAD;
    endfunction

    function automatic logic [7:0] char_of(input int s);
        if (s < 26)
            return 8'("A" + s);
        if (s < 52)
            return 8'("a" + s - 26);
        if (s < 62)
            return 8'("0" + s - 52);
        return (s == 62) ? "+" : "/";
    endfunction

    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? 8'd32 : 8'(9 + r);
    endfunction

    function automatic logic [7:0] bad_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (sextet_of(c) != SXT_BAD);
        return c;
    endfunction

    function automatic longint unsigned byte_limit();
        longint unsigned cmax;
        cmax = (64'd1 << COUNT_W) - 1;
        return (cap_model < cmax) ? cap_model : cmax;
    endfunction

    task automatic due_byte(input logic [7:0] b);
        decoder_out_due.push_back('{b64d_pkg::KIND_DATA, b, b64d_pkg::ST_OK, 32'd0, 1'b0});
    endtask

    task automatic due_status(input logic [1:0] st, input logic [31:0] n);
        decoder_out_due.push_back('{b64d_pkg::KIND_STATUS, 8'd0, st, n, 1'b1});
    endtask

    task automatic clear_message();
        dec_acc = '0;
        dec_cnt = 0;
        dec_made = 0;
        dec_mode = DEC_DATA;
    endtask

    task automatic abort_message(input logic [1:0] st, input bit at_end);
        due_status(st, 32'd0);
        clear_message();
        if (!at_end)
            dec_mode = DEC_DROP;
    endtask

    task automatic close_message();
        longint unsigned tail;
        tail = (dec_cnt == 3) ? 2 : ((dec_cnt == 2) ? 1 : 0);
        if (dec_made + tail > byte_limit())
        begin
            abort_message(b64d_pkg::ST_NO_ROOM, 1'b1);
            return;
        end
        if (dec_cnt == 3)
        begin
            due_byte(dec_acc[17:10]);
            due_byte(dec_acc[9:2]);
        end
        else if (dec_cnt == 2)
        begin
            due_byte(dec_acc[11:4]);
        end
        due_status(b64d_pkg::ST_OK, 32'(dec_made + tail));
        clear_message();
    endtask

    task automatic decode_char(input logic [7:0] c, input logic at_end);
        int s;
        if (dec_mode == DEC_DROP || dec_mode == 2'd3)
        begin
            if (at_end)
                clear_message();
            return;
        end
        if (dec_mode == DEC_PAD)
        begin
            if (at_end)
                close_message();
            return;
        end
        s = sextet_of(c);
        if (s == SXT_BAD)
        begin
            abort_message(b64d_pkg::ST_BAD_CHAR, at_end);
            return;
        end
        if (s == SXT_PAD)
        begin
            dec_mode = DEC_PAD;
        end
        else if (s != SXT_SKIP)
        begin
            dec_acc = {dec_acc[17:0], 6'(s)};
            dec_cnt++;
            if (dec_cnt == 4)
            begin
                // a group that does not fit emits none of its bytes
                if (dec_made + 3 > byte_limit())
                begin
                    abort_message(b64d_pkg::ST_NO_ROOM, at_end);
                    return;
                end
                due_byte(dec_acc[23:16]);
                due_byte(dec_acc[15:8]);
                due_byte(dec_acc[7:0]);
                dec_made += 3;
                dec_acc = '0;
                dec_cnt = 0;
            end
        end
        if (at_end)
            close_message();
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
            fails++;
        end
    endtask

    // Sample acceptances, advance the mirror, check results
    always @(posedge clk)
    begin : watch
        out_item_t want;
        cycle_cnt++;
        in_taken = rst_n && push && !full;
        if (rst_n && push && full)
            full_cycles++;
        if (in_taken)
            decode_char(char_code, message_end);
        if (rst_n && cfg_valid && cfg_ready)
            cap_model = cfg_data;
        if (rst_n && pop && !empty)
        begin
            if (item_kind === b64d_pkg::KIND_DATA)
                bytes_seen++;
            else if (status_code < 3)
                status_seen[status_code]++;
            if (decoder_out_due.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, %s %0h byte %0h status %0h count %0d",
                         $time, "actual kind", item_kind, decoded_byte, status_code,
                         byte_count);
                fails++;
            end
            else
            begin
                want = decoder_out_due.pop_front();
                check_field("item_kind", want.kind, item_kind);
                check_field("decoded_byte", want.data, decoded_byte);
                check_field("status_code", want.status, status_code);
                check_field("byte_count", want.count, byte_count);
                check_field("last_result", want.last, last_result);
            end
        end
    end

    always @(negedge clk)
    begin : drive_chars
        char_item_t it;
        if (rst_n && (!push || in_taken))
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                push <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                src_gap = $urandom_range(1, 17) - 1;
                push <= 1'b0;
            end
            else if (char_stream.size() > 0)
            begin
                it = char_stream.pop_front();
                push <= 1'b1;
                char_code <= it.code;
                message_end <= it.last;
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : drive_pop
        if (!rst_n || rx_hold)
        begin
            pop <= 1'b0;
        end
        else if (snk_gap > 0)
        begin
            snk_gap--;
            pop <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 11) == 0)
        begin
            snk_gap = $urandom_range(1, 17) - 1;
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    task automatic add_char(input logic [7:0] c, input logic at_end);
        char_stream.push_back('{c, at_end});
        chars_queued++;
        if (at_end)
            msgs_queued++;
    endtask

    task automatic queue_message(input bit broken);
        logic [7:0] chars[$];
        int nsx;
        nsx = $urandom_range(1, 14);
        if ($urandom_range(0, 7) == 0)
            nsx = $urandom_range(15, 40);
        for (int k = 0; k < nsx; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                chars.push_back(blank_char());
            chars.push_back(char_of($urandom_range(0, 63)));
        end
        if (nsx % 4 != 0 && $urandom_range(0, 1) == 1)
        begin
            repeat (4 - nsx % 4) chars.push_back(CH_PAD);
            // anything after the pad is ignored, valid or not
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) chars.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 7) == 0)
            chars.push_back(blank_char());
        if (broken)
            chars.insert($urandom_range(0, chars.size() - 1), bad_char());
        foreach (chars[i])
            add_char(chars[i], i == chars.size() - 1);
    endtask

    task automatic queue_traffic(input int n);
        int start;
        int pick;
        start = chars_queued;
        while (chars_queued - start < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 72)
            begin
                queue_message(1'b0);
            end
            else if (pick < 87)
            begin
                queue_message(1'b1);
            end
            else
            begin
                repeat ($urandom_range(0, 3)) add_char(8'($urandom_range(0, 255)), 1'b0);
                add_char(8'($urandom_range(0, 255)), 1'b1);
            end
        end
    endtask

    task automatic wait_idle();
        while (char_stream.size() != 0 || push || decoder_out_due.size() != 0)
            @(posedge clk);
        repeat (IDLE_TAIL) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [31:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
            @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // full group, extreme sextets with blanks, tails after pad, lone sextet
        add_char("T", 1'b0);
        add_char("W", 1'b0);
        add_char("F", 1'b0);
        add_char("u", 1'b1);
        add_char("/", 1'b0);
        add_char(8'd9, 1'b0);
        add_char("+", 1'b0);
        add_char(8'd32, 1'b0);
        add_char("9", 1'b0);
        add_char("z", 1'b0);
        add_char(8'd13, 1'b1);
        add_char("Q", 1'b0);
        add_char("Q", 1'b0);
        add_char(CH_PAD, 1'b0);
        add_char(8'd255, 1'b1);
        add_char("Q", 1'b0);
        add_char("U", 1'b0);
        add_char("I", 1'b0);
        add_char(CH_PAD, 1'b1);
        add_char("Q", 1'b1);
        // bad char on the final item, then bad char mid message
        add_char(8'd0, 1'b1);
        add_char("A", 1'b0);
        add_char(8'd128, 1'b0);
        add_char("B", 1'b1);
        wait_idle();

        write_capacity(32'd0);
        queue_traffic(40);
        wait_idle();

        write_capacity(32'($urandom_range(1, 9)));
        queue_traffic(60);
        // hold the result side so the block backs up into full
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
        wait_idle();

        write_capacity(32'hFFFF_FFFF);
        queue_traffic(90);
        wait_idle();

        write_capacity(32'($urandom_range(10, 60)));
        queue_traffic(60);
        wait_idle();

        calm = 1'b1;
        write_capacity($urandom);
        queue_traffic(100);
        wait_idle();

        $display("Decoded %0d chars in %0d messages: %0d bytes, %0d ok / %0d bad char / %s",
                 chars_queued, msgs_queued, bytes_seen, status_seen[0], status_seen[1],
                 $sformatf("%0d no room", status_seen[2]));
        $display("Capacity swept over zero, small, full and random; %s %0d cycles",
                 "input backed up on", full_cycles);
        if (fails == 0 && decoder_out_due.size() == 0 && empty)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("%0d mismatches, %0d items never arrived, leftover result %0b",
                     fails, decoder_out_due.size(), !empty);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
